/* hdl/bbat_pkg.sv */
// Package for the button binding autorepeat table.
// Request codes, event codes, directional button codes, FSM state type.
`default_nettype none
package bbat_pkg;

    localparam int TableEntriesDefault = 16;
    localparam logic [15:0] DelayReset    = 16'd500;
    localparam logic [15:0] IntervalReset = 16'd100;

    localparam logic [2:0] REQ_DECIDE   = 3'd0;
    localparam logic [2:0] REQ_BIND     = 3'd1;
    localparam logic [2:0] REQ_UNBIND   = 3'd2;
    localparam logic [2:0] REQ_CLEAR    = 3'd3;
    localparam logic [2:0] REQ_RESET    = 3'd4;
    localparam logic [2:0] REQ_HASMAP   = 3'd5;

    localparam logic [1:0] EV_NONE     = 2'd0;
    localparam logic [1:0] EV_PRESSED  = 2'd1;
    localparam logic [1:0] EV_RELEASED = 2'd2;
    localparam logic [1:0] EV_REPEAT   = 2'd3;

    localparam logic [0:0] CFG_DELAY    = 1'b0;
    localparam logic [0:0] CFG_INTERVAL = 1'b1;

    localparam logic [31:0] DIR_UP    = 32'h0001_0001;
    localparam logic [31:0] DIR_DOWN  = 32'h0001_0002;
    localparam logic [31:0] DIR_LEFT  = 32'h0001_0004;
    localparam logic [31:0] DIR_RIGHT = 32'h0001_0008;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ACT,
        ST_CATCH,
        ST_DONE
    } state_t;

    function automatic logic is_dir(input logic [31:0] code);
        return code == DIR_UP || code == DIR_DOWN || code == DIR_LEFT || code == DIR_RIGHT;
    endfunction

endpackage
`default_nettype wire

/* hdl/button_binding_autorepeat_table.sv */
// Button binding table with key autorepeat decisions.
// Entry keys and next-repeat times live in one synchronous memory; uses bbat_pkg.
//
//  channel   signals                                          direction
//  request   start, req_type, view_id, button, ... (busy is out)  in
//  result    done, ok, mapped, event_res, entry_index         out
//  config    cfg_we, cfg_index, cfg_data                      in
//
// Each request scans every entry, one memory read a cycle, then acts on the
// entry found; a repeat adds catch-up steps. busy drops the cycle after
// done, and no new word is accepted while busy.
// Catch-up steps add the interval until it passes the held time.
// Reset clears valid and pressed flags (flip-flops); memory is left as is.
// Result is valid in the cycle of done; the receiver cannot stall.
`default_nettype none
module button_binding_autorepeat_table
    import bbat_pkg::*;
#(
    parameter int TABLE_ENTRIES = TableEntriesDefault
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  req_type,
    input  wire logic [15:0] view_id,
    input  wire logic [31:0] button,
    input  wire logic        just_pressed,
    input  wire logic        is_released,
    input  wire logic [15:0] held_ticks,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    output logic             done,
    output logic             ok,
    output logic             mapped,
    output logic [1:0]       event_res,
    output logic [3:0]       entry_index
);

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    // memory word: view, button, next_repeat
    logic [64:0] mem [TABLE_ENTRIES];
    logic [64:0] rd_reg;

    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic [TABLE_ENTRIES-1:0] press_reg, press_next;

    logic [15:0] delay_reg, interval_reg;

    state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] rd_idx_reg;        // address of word in rd_reg
    logic          rd_live_reg;

    logic [2:0]  q_req_reg;
    logic [15:0] q_view_reg;
    logic [31:0] q_btn_reg;
    logic        q_jp_reg, q_rel_reg;
    logic [15:0] q_held_reg;

    logic          hit_reg, hit_next, free_reg, free_next, any_reg, any_next;
    logic [AW-1:0] hit_idx_reg, hit_idx_next, free_idx_reg, free_idx_next;
    logic [16:0]   nr_reg, nr_next;   // next-repeat of hit entry, then catch-up value

    logic          we;
    logic [AW-1:0] wa;
    logic [64:0]   wd;

    logic        r_ok_reg, r_ok_next, r_map_reg, r_map_next;
    logic [1:0]  r_ev_reg, r_ev_next;
    logic [3:0]  r_idx_reg, r_idx_next;

    logic        match, view_match;
    logic [15:0] iv;

    assign iv = (interval_reg == 16'd0) ? 16'd1 : interval_reg;
    assign view_match = valid_reg[rd_idx_reg] && rd_reg[64:49] == q_view_reg;
    assign match = view_match && rd_reg[48:17] == q_btn_reg;
    assign rd_addr = cnt_reg[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg    <= DelayReset;
            interval_reg <= IntervalReset;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DELAY:    delay_reg <= cfg_data;
                CFG_INTERVAL: interval_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        rd_reg <= mem[rd_addr];
        rd_idx_reg <= rd_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            press_reg   <= '0;
            cnt_reg     <= '0;
            rd_live_reg <= 1'b0;
            done        <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            press_reg   <= press_next;
            cnt_reg     <= cnt_next;
            rd_live_reg <= state_reg == ST_SCAN && cnt_reg < CW'(TABLE_ENTRIES);
            done        <= state_next == ST_DONE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            q_req_reg  <= req_type;
            q_view_reg <= view_id;
            q_btn_reg  <= button;
            q_jp_reg   <= just_pressed;
            q_rel_reg  <= is_released;
            q_held_reg <= held_ticks;
        end
        hit_reg      <= hit_next;
        hit_idx_reg  <= hit_idx_next;
        free_reg     <= free_next;
        free_idx_reg <= free_idx_next;
        any_reg      <= any_next;
        nr_reg       <= nr_next;
        r_ok_reg     <= r_ok_next;
        r_map_reg    <= r_map_next;
        r_ev_reg     <= r_ev_next;
        r_idx_reg    <= r_idx_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (start) state_next = ST_SCAN;
            ST_SCAN:  if (cnt_reg == CW'(TABLE_ENTRIES) && !rd_live_reg) state_next = ST_ACT;
            ST_ACT:
                if (q_req_reg == REQ_DECIDE && hit_reg && !(q_rel_reg && press_reg[hit_idx_reg])
                    && !(q_jp_reg && !press_reg[hit_idx_reg]) && press_reg[hit_idx_reg]
                    && is_dir(q_btn_reg) && {1'b0, q_held_reg} >= nr_reg)
                    state_next = ST_CATCH;
                else
                    state_next = ST_DONE;
            ST_CATCH: if (nr_reg + {1'b0, iv} > {1'b0, q_held_reg}) state_next = ST_DONE;
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cnt_next      = cnt_reg;
        valid_next    = valid_reg;
        press_next    = press_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        any_next      = any_reg;
        nr_next       = nr_reg;
        r_ok_next     = r_ok_reg;
        r_map_next    = r_map_reg;
        r_ev_next     = r_ev_reg;
        r_idx_next    = r_idx_reg;
        we = 1'b0;
        wa = hit_idx_reg;
        wd = {q_view_reg, q_btn_reg, nr_reg};
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                hit_next = 1'b0;
                free_next = 1'b0;
                any_next = 1'b0;
                r_ok_next = 1'b0;
                r_map_next = 1'b0;
                r_ev_next = EV_NONE;
                r_idx_next = '0;
            end
            ST_SCAN:
            begin
                if (cnt_reg < CW'(TABLE_ENTRIES))
                    cnt_next = cnt_reg + 1'b1;
                if (rd_live_reg)
                begin
                    if (view_match)
                    begin
                        any_next = 1'b1;
                        if (q_req_reg == REQ_CLEAR)
                        begin
                            valid_next[rd_idx_reg] = 1'b0;
                            press_next[rd_idx_reg] = 1'b0;
                        end
                        if (q_req_reg == REQ_RESET)
                            press_next[rd_idx_reg] = 1'b0;
                    end
                    if (match && !hit_reg)
                    begin
                        hit_next = 1'b1;
                        hit_idx_next = rd_idx_reg;
                        nr_next = rd_reg[16:0];
                    end
                    if (!valid_reg[rd_idx_reg] && !free_reg)
                    begin
                        free_next = 1'b1;
                        free_idx_next = rd_idx_reg;
                    end
                end
            end
            ST_ACT:
            begin
                case (q_req_reg)
                    REQ_DECIDE:
                        if (hit_reg)
                        begin
                            r_map_next = 1'b1;
                            r_idx_next = 4'(hit_idx_reg);
                            if (q_rel_reg && press_reg[hit_idx_reg])
                            begin
                                press_next[hit_idx_reg] = 1'b0;
                                r_ev_next = EV_RELEASED;
                            end
                            else if (q_jp_reg && !q_rel_reg && !press_reg[hit_idx_reg])
                            begin
                                press_next[hit_idx_reg] = 1'b1;
                                we = 1'b1;
                                wd = {q_view_reg, q_btn_reg, 1'b0, delay_reg};
                                r_ev_next = EV_PRESSED;
                            end
                            else if (state_next == ST_CATCH)
                            begin
                                r_ev_next = EV_REPEAT;
                            end
                        end
                    REQ_BIND:
                        if (q_view_reg != 16'd0 && (hit_reg || free_reg))
                        begin
                            wa = hit_reg ? hit_idx_reg : free_idx_reg;
                            we = 1'b1;
                            wd = {q_view_reg, q_btn_reg, 17'd0};
                            valid_next[wa] = 1'b1;
                            press_next[wa] = 1'b0;
                            r_ok_next = 1'b1;
                            r_idx_next = 4'(wa);
                        end
                    REQ_UNBIND:
                        if (hit_reg)
                        begin
                            valid_next[hit_idx_reg] = 1'b0;
                            press_next[hit_idx_reg] = 1'b0;
                            r_ok_next = 1'b1;
                            r_idx_next = 4'(hit_idx_reg);
                        end
                    REQ_HASMAP: r_ok_next = any_reg;
                    default: ;
                endcase
            end
            ST_CATCH:
            begin
                nr_next = nr_reg + {1'b0, iv};
                if (state_next == ST_DONE)
                begin
                    we = 1'b1;
                    wd = {q_view_reg, q_btn_reg, nr_next};
                end
            end
            default: ;
        endcase
    end

    assign busy        = state_reg != ST_IDLE;
    assign ok          = r_ok_reg;
    assign mapped      = r_map_reg;
    assign event_res   = r_ev_reg;
    assign entry_index = r_idx_reg;

    a_done_one: assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("done held two cycles");
    a_press_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (press_reg & ~valid_reg) == '0)
        else $error("pressed flag on invalid entry");
    a_map_decide: assert property (@(posedge clk) disable iff (!rst_n)
        done && mapped |-> !ok)
        else $error("mapped and ok together");

endmodule
`default_nettype wire

/* tb/bbat_checker.sv */
// Checker for the button binding autorepeat table: watches request, result and
// config ports, keeps its own binding table and predicts every result word.
// Depends on bbat_pkg for request, event and register codes.
`timescale 1ns / 1ps
module bbat_checker
    import bbat_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [2:0]  req_type,
    input  logic [15:0] view_id,
    input  logic [31:0] button,
    input  logic        just_pressed,
    input  logic        is_released,
    input  logic [15:0] held_ticks,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        done,
    input  logic        ok,
    input  logic        mapped,
    input  logic [1:0]  event_res,
    input  logic [3:0]  entry_index,
    output int          fail_count,
    output int          words_pending
);
    localparam int Entries = 16;

    typedef struct packed {
        logic       ok;
        logic       mapped;
        logic [1:0] ev;
        logic [3:0] idx;
    } answer_t;

    logic        tbl_valid   [Entries];
    logic [15:0] tbl_view    [Entries];
    logic [31:0] tbl_button  [Entries];
    logic        tbl_pressed [Entries];
    logic [16:0] tbl_next    [Entries];
    logic [15:0] delay_ticks;
    logic [15:0] interval_ticks;
    answer_t     answers_due[$];

    function automatic int lookup(input logic [15:0] v, input logic [31:0] b);
        for (int i = 0; i < Entries; i++)
            if (tbl_valid[i] && tbl_view[i] == v && tbl_button[i] == b)
                return i;
        return -1;
    endfunction

    function automatic answer_t apply_request(input logic [2:0] rq, input logic [15:0] v,
                                              input logic [31:0] b, input logic jp,
                                              input logic rel, input logic [15:0] held);
        answer_t a;
        int e;
        logic [31:0] iv;
        logic [31:0] steps;
        a = '0;
        case (rq)
            REQ_DECIDE: begin
                e = lookup(v, b);
                if (e >= 0) begin
                    a.mapped = 1'b1;
                    a.idx = e[3:0];
                    if (rel && tbl_pressed[e]) begin
                        tbl_pressed[e] = 1'b0;
                        a.ev = EV_RELEASED;
                    end else if (jp && !rel && !tbl_pressed[e]) begin
                        tbl_pressed[e] = 1'b1;
                        tbl_next[e] = {1'b0, delay_ticks};
                        a.ev = EV_PRESSED;
                    end else if (tbl_pressed[e] && (b == DIR_UP || b == DIR_DOWN ||
                                 b == DIR_LEFT || b == DIR_RIGHT) &&
                                 {16'd0, held} >= {15'd0, tbl_next[e]}) begin
                        iv = (interval_ticks == 0) ? 32'd1 : {16'd0, interval_ticks};
                        steps = ({16'd0, held} - {15'd0, tbl_next[e]}) / iv + 1;
                        tbl_next[e] = 17'({15'd0, tbl_next[e]} + steps * iv);
                        a.ev = EV_REPEAT;
                    end
                end
            end
            REQ_BIND: begin
                if (v != 0) begin
                    e = lookup(v, b);
                    if (e < 0)
                        for (int i = 0; i < Entries; i++)
                            if (!tbl_valid[i] && e < 0)
                                e = i;
                    if (e >= 0) begin
                        tbl_valid[e] = 1'b1;
                        tbl_view[e] = v;
                        tbl_button[e] = b;
                        tbl_pressed[e] = 1'b0;
                        tbl_next[e] = '0;
                        a.ok = 1'b1;
                        a.idx = e[3:0];
                    end
                end
            end
            REQ_UNBIND: begin
                e = lookup(v, b);
                if (e >= 0) begin
                    tbl_valid[e] = 1'b0;
                    tbl_pressed[e] = 1'b0;
                    a.ok = 1'b1;
                    a.idx = e[3:0];
                end
            end
            REQ_CLEAR, REQ_RESET, REQ_HASMAP: begin
                for (int i = 0; i < Entries; i++)
                    if (tbl_valid[i] && tbl_view[i] == v) begin
                        if (rq == REQ_CLEAR)
                            tbl_valid[i] = 1'b0;
                        if (rq != REQ_HASMAP)
                            tbl_pressed[i] = 1'b0;
                        else
                            a.ok = 1'b1;
                    end
            end
            default: ;
        endcase
        return a;
    endfunction

    assign words_pending = answers_due.size();

    always @(posedge clk or negedge rst_n)
    begin
        answer_t exp_a;
        if (!rst_n) begin
            for (int i = 0; i < Entries; i++) begin
                tbl_valid[i] = 1'b0;
                tbl_pressed[i] = 1'b0;
                tbl_view[i] = '0;
                tbl_button[i] = '0;
                tbl_next[i] = '0;
            end
            delay_ticks = DelayReset;
            interval_ticks = IntervalReset;
            answers_due.delete();
            fail_count = 0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_DELAY)
                    delay_ticks = cfg_data;
                else
                    interval_ticks = cfg_data;
            end
            if (start && !busy)
                answers_due.push_back(apply_request(req_type, view_id, button,
                                                    just_pressed, is_released, held_ticks));
            if (done) begin
                if (answers_due.size() == 0) begin
                    $error("result word with nothing expected");
                    fail_count++;
                end else begin
                    exp_a = answers_due.pop_front();
                    if (ok !== exp_a.ok) begin
                        $error("ok: expected %0d, got %0d", exp_a.ok, ok);
                        fail_count++;
                    end
                    if (mapped !== exp_a.mapped) begin
                        $error("mapped: expected %0d, got %0d", exp_a.mapped, mapped);
                        fail_count++;
                    end
                    if (event_res !== exp_a.ev) begin
                        $error("event_res: expected %0d, got %0d", exp_a.ev, event_res);
                        fail_count++;
                    end
                    if (entry_index !== exp_a.idx) begin
                        $error("entry_index: expected %0d, got %0d", exp_a.idx, entry_index);
                        fail_count++;
                    end
                end
            end
        end
    end
endmodule

/* tb/tb_top.sv */
// Top of the button binding autorepeat table testbench: clock, reset, config
// phases, directed and random request words, and the verdict.
// Depends on bbat_pkg, the block, and bbat_checker.
`timescale 1ns / 1ps
module tb_top;
    import bbat_pkg::*;

    localparam logic [2:0] REQ_SPARE_A = 3'd6;
    localparam logic [2:0] REQ_SPARE_B = 3'd7;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  req_type = '0;
    logic [15:0] view_id = '0;
    logic [31:0] button = '0;
    logic        just_pressed = 1'b0;
    logic        is_released = 1'b0;
    logic [15:0] held_ticks = '0;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        done, ok, mapped;
    logic [1:0]  event_res;
    logic [3:0]  entry_index;
    int          fail_count;
    int          words_pending;
    int          held_cap;
    bit          gaps_on;

    always #10 clk = ~clk;

    button_binding_autorepeat_table dut (.*);
    bbat_checker chk (.*);

    initial
    begin
        #1_000_000_000;
        $display("simulation failed");
        $finish;
    end

    task automatic send_word(input logic [2:0] rq, input logic [15:0] v, input logic [31:0] b,
                             input logic jp, input logic rel, input logic [15:0] held);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        req_type <= rq;
        view_id <= v;
        button <= b;
        just_pressed <= jp;
        is_released <= rel;
        held_ticks <= held;
        start <= 1'b1;
        // busy only moves at the rising edge, so look at it mid-cycle
        do @(negedge clk); while (busy);
        @(posedge clk);
    endtask

    task automatic drain;
        start <= 1'b0;
        do @(negedge clk); while (words_pending != 0 || busy);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [15:0] val);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] pick_button();
        case ($urandom_range(0, 9))
            0: return DIR_UP;
            1: return DIR_DOWN;
            2, 3: return DIR_LEFT;
            4: return DIR_RIGHT;
            5: return 32'h20;
            6: return 32'h21;
            7: return 32'h0001_0010;
            default: return $urandom();
        endcase
    endfunction

    task automatic random_word;
        logic [2:0]  rq;
        logic [15:0] v;
        logic [31:0] b;
        logic [15:0] held;
        int r;
        r = $urandom_range(0, 99);
        rq = r < 50 ? REQ_DECIDE : r < 70 ? REQ_BIND : r < 78 ? REQ_UNBIND :
             r < 82 ? REQ_CLEAR : r < 86 ? REQ_RESET : r < 92 ? REQ_HASMAP :
             3'($urandom_range(REQ_SPARE_A, REQ_SPARE_B));
        v = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(1, 3));
        b = pick_button();
        held = ($urandom_range(0, 9) == 0) ? 16'(held_cap) : 16'($urandom_range(0, held_cap));
        send_word(rq, v, b, $urandom_range(0, 9) < 4, $urandom_range(0, 3) == 0, held);
    endtask

    initial
    begin
        held_cap = 65535;
        gaps_on = 1'b1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: bind rules, press/repeat/release, table-wide requests
        send_word(REQ_BIND, 16'd0, DIR_UP, 0, 0, 0);
        send_word(REQ_BIND, 16'd1, DIR_UP, 0, 0, 0);
        send_word(REQ_BIND, 16'hFFFF, 32'hFFFF_FFFF, 1, 1, 16'hFFFF);
        send_word(REQ_BIND, 16'd1, 32'h20, 0, 0, 0);
        send_word(REQ_DECIDE, 16'd1, DIR_UP, 1, 0, 0);
        send_word(REQ_DECIDE, 16'd1, DIR_UP, 0, 0, 499);
        send_word(REQ_DECIDE, 16'd1, DIR_UP, 0, 0, 500);
        send_word(REQ_DECIDE, 16'd1, DIR_UP, 0, 0, 16'hFFFF);
        send_word(REQ_DECIDE, 16'd1, DIR_UP, 0, 1, 0);
        send_word(REQ_DECIDE, 16'd1, 32'h20, 1, 0, 0);
        send_word(REQ_DECIDE, 16'd1, 32'h20, 0, 0, 16'hFFFF);
        send_word(REQ_DECIDE, 16'hFFFF, 32'hFFFF_FFFF, 1, 1, 0);
        send_word(REQ_BIND, 16'd1, 32'h20, 0, 0, 0);
        send_word(REQ_DECIDE, 16'd2, DIR_DOWN, 1, 0, 0);
        send_word(REQ_UNBIND, 16'd2, DIR_DOWN, 0, 0, 0);
        send_word(REQ_HASMAP, 16'd1, 0, 0, 0, 0);
        send_word(REQ_HASMAP, 16'd2, 0, 0, 0, 0);
        send_word(REQ_DECIDE, 16'd1, DIR_UP, 1, 0, 0);
        send_word(REQ_RESET, 16'd1, 0, 0, 0, 0);
        send_word(REQ_DECIDE, 16'd1, DIR_UP, 0, 0, 600);
        send_word(REQ_SPARE_A, 16'd1, DIR_UP, 1, 1, 16'hFFFF);
        send_word(REQ_SPARE_B, 16'hFFFF, 32'hFFFF_FFFF, 1, 1, 16'hFFFF);
        send_word(REQ_CLEAR, 16'd1, 0, 0, 0, 0);
        send_word(REQ_UNBIND, 16'hFFFF, 32'hFFFF_FFFF, 0, 0, 0);
        send_word(REQ_HASMAP, 16'd1, 0, 0, 0, 0);

        // random phases: reset values, then extremes, then random settings
        repeat (85) random_word();
        held_cap = 64;
        write_reg(CFG_DELAY, 16'd1);
        write_reg(CFG_INTERVAL, 16'd1);
        repeat (85) random_word();
        held_cap = 65535;
        write_reg(CFG_DELAY, 16'hFFFF);
        write_reg(CFG_INTERVAL, 16'hFFFF);
        repeat (85) random_word();
        held_cap = 64;
        write_reg(CFG_DELAY, 16'd0);
        write_reg(CFG_INTERVAL, 16'd0);
        repeat (85) random_word();
        held_cap = 65535;
        write_reg(CFG_DELAY, 16'($urandom_range(1, 2000)));
        write_reg(CFG_INTERVAL, 16'($urandom_range(20, 1000)));
        repeat (50) random_word();
        gaps_on = 1'b0;
        repeat (60) random_word();

        drain();
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
